FILE: rtl/core/ttsdg_pkg.sv
package ttsdg_pkg;

  localparam int NUM_TONES_DEF      = 2;
  localparam int SINE_ADDR_BITS_DEF = 10;

  localparam int AMP_W   = 16;
  localparam int STEP_W  = 32;
  localparam int PHASE_W = 32;
  localparam int SINE_W  = 16;
  localparam int MAG_W   = 15;
  localparam int CODE_W  = 8;
  localparam int SUM_W   = AMP_W + 1;
  localparam int PROD_W  = AMP_W + 1 + SINE_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int NUM_W   = ACC_W + 1;
  localparam int REM_W   = NUM_W + CODE_W;
  localparam int HALF_SHIFT = SINE_W - 1;
  localparam int DEN_SHIFT  = SINE_W + CODE_W - 1;
  localparam int DATA_W  = 32;
  localparam int CFG_AW  = 4;

  localparam logic [AMP_W-1:0]  AMP_A_RST  = 16'd16384;
  localparam logic [AMP_W-1:0]  AMP_B_RST  = 16'd8192;
  localparam logic [STEP_W-1:0] STEP_A_RST = 32'd8589935;
  localparam logic [STEP_W-1:0] STEP_B_RST = 32'd21474836;
  localparam logic [CODE_W-1:0] CODE_MID   = 8'd127;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] MAG_MAX     = 64'd32767;

  typedef enum logic [1:0] {
    REG_AMP_A  = 2'd0,
    REG_AMP_B  = 2'd1,
    REG_STEP_A = 2'd2,
    REG_STEP_B = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [AMP_W-1:0]  amp_a;
    logic [AMP_W-1:0]  amp_b;
    logic [STEP_W-1:0] step_a;
    logic [STEP_W-1:0] step_b;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } state_t;

  function automatic logic [MAG_W-1:0] sine_mag(int unsigned u, int unsigned addr_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] h;
    logic [63:0] s;
    logic [63:0] mag;
    x   = (HALF_PI_Q30 * 64'(u)) >> (addr_bits - 2);
    x2  = (x * x) >> 30;
    h   = ONE_Q30;
    h   = ONE_Q30 - ((x2 * h) >> 30) / 64'd110;
    h   = ONE_Q30 - ((x2 * h) >> 30) / 64'd72;
    h   = ONE_Q30 - ((x2 * h) >> 30) / 64'd42;
    h   = ONE_Q30 - ((x2 * h) >> 30) / 64'd20;
    h   = ONE_Q30 - ((x2 * h) >> 30) / 64'd6;
    s   = (x * h) >> 30;
    mag = (s * MAG_MAX + (64'd1 << 29)) >> 30;
    if (mag > MAG_MAX) begin
      mag = MAG_MAX;
    end
    return mag[MAG_W-1:0];
  endfunction

endpackage

FILE: rtl/core/ttsdg_ram.sv
module ttsdg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

FILE: rtl/core/ttsdg_sine_rom.sv
module ttsdg_sine_rom #(
  parameter int ADDR_BITS = ttsdg_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                                clk,
  input  logic [ADDR_BITS-1:0]                addr,
  output logic signed [ttsdg_pkg::SINE_W-1:0] sine_r
);
  import ttsdg_pkg::*;

  localparam int QW    = ADDR_BITS - 2;
  localparam int DEPTH = (1 << QW) + 1;
  localparam logic [QW:0] QUARTER = {1'b1, {QW{1'b0}}};

  logic [MAG_W-1:0] mag_tbl [DEPTH];
  logic [1:0]       quad;
  logic [QW:0]      t_ext;
  logic [QW:0]      u;
  logic [MAG_W-1:0] mag;

  for (genvar k = 0; k < DEPTH; k++) begin : g_tbl
    assign mag_tbl[k] = sine_mag(k, ADDR_BITS);
  end

  assign quad  = addr[ADDR_BITS-1 -: 2];
  assign t_ext = {1'b0, addr[QW-1:0]};
  assign u     = quad[0] ? (QUARTER - t_ext) : t_ext;
  assign mag   = mag_tbl[u];

  always_ff @(posedge clk) begin
    if (quad[1]) begin
      sine_r <= -$signed({1'b0, mag});
    end else begin
      sine_r <= $signed({1'b0, mag});
    end
  end

endmodule

FILE: rtl/core/ttsdg_regs.sv
module ttsdg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ttsdg_pkg::CFG_AW-1:0]       paddr,
  input  logic [ttsdg_pkg::DATA_W-1:0]       pwdata,
  output logic [ttsdg_pkg::DATA_W-1:0]       prdata,
  output logic                               pready,
  output ttsdg_pkg::cfg_t                    cfg
);
  import ttsdg_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{amp_a: AMP_A_RST, amp_b: AMP_B_RST, step_a: STEP_A_RST, step_b: STEP_B_RST};
    end else if (wr_en) begin
      case (idx)
        REG_AMP_A: begin
          cfg_r.amp_a <= pwdata[AMP_W-1:0];
        end
        REG_AMP_B: begin
          cfg_r.amp_b <= pwdata[AMP_W-1:0];
        end
        REG_STEP_A: begin
          cfg_r.step_a <= pwdata[STEP_W-1:0];
        end
        REG_STEP_B: begin
          cfg_r.step_b <= pwdata[STEP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_AMP_A:  prdata = DATA_W'(cfg_r.amp_a);
      REG_AMP_B:  prdata = DATA_W'(cfg_r.amp_b);
      REG_STEP_A: prdata = DATA_W'(cfg_r.step_a);
      REG_STEP_B: prdata = DATA_W'(cfg_r.step_b);
      default:    prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/ttsdg_div.sv
module ttsdg_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [ttsdg_pkg::REM_W-1:0]       numer,
  input  logic [ttsdg_pkg::SUM_W-1:0]       sum_amp,
  output logic                              done,
  output logic [ttsdg_pkg::CODE_W-1:0]      quot
);
  import ttsdg_pkg::*;

  localparam int CW = $clog2(CODE_W);

  logic [REM_W-1:0]  rem_r;
  logic [REM_W-1:0]  dsh_r;
  logic [CODE_W-1:0] quot_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W:0]    diff;
  logic              ge;

  assign diff = {1'b0, rem_r} - {1'b0, dsh_r};
  assign ge   = !diff[REM_W];
  assign done = done_r;
  assign quot = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(CODE_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= numer;
      dsh_r  <= REM_W'({sum_amp, {DEN_SHIFT{1'b0}}});
      quot_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= diff[REM_W-1:0];
      end
      quot_r <= {quot_r[CODE_W-2:0], ge};
      dsh_r  <= dsh_r >> 1;
    end
  end

endmodule

FILE: rtl/core/two_tone_sine_dac_generator_top.sv
// A request is taken only in the idle state, so a new request waits until the last result
// has been loaded into the output register; each tone costs a phase memory read, a table
// lookup and a multiply, and the normalization is an eight-step restoring divider, which is
// skipped when the amplitude sum is zero, giving the mid code instead.
// Reset is synchronous and active low: registers return to their defaults and both phase
// accumulators read as zero until written, with no clearing pass.
module two_tone_sine_dac_generator_top #(
  parameter int NUM_TONES      = ttsdg_pkg::NUM_TONES_DEF,
  parameter int SINE_ADDR_BITS = ttsdg_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_clear_phases,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ttsdg_pkg::CODE_W-1:0]      out_dac_code,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ttsdg_pkg::CFG_AW-1:0]      paddr,
  input  logic [ttsdg_pkg::DATA_W-1:0]      pwdata,
  output logic [ttsdg_pkg::DATA_W-1:0]      prdata,
  output logic                              pready
);
  import ttsdg_pkg::*;

  localparam int TW = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;
  localparam logic [TW-1:0] LAST_TONE = TW'(NUM_TONES - 1);

  cfg_t                      cfg;
  state_t                    state_r;
  state_t                    state_nxt;
  logic [TW-1:0]             tone_r;
  logic                      clr_r;
  logic [NUM_TONES-1:0]      valid_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      out_valid_r;
  logic [CODE_W-1:0]         code_r;

  logic [STEP_W-1:0]         step_sel;
  logic [AMP_W-1:0]          amp_sel;
  logic [SUM_W-1:0]          sum_amp;
  logic [PHASE_W-1:0]        ph_rdata;
  logic [PHASE_W-1:0]        ph_old;
  logic [PHASE_W-1:0]        ph_new;
  logic                      ph_we;
  logic [TW-1:0]             ph_raddr;
  logic signed [SINE_W-1:0]  sine;
  logic [NUM_W-1:0]          n_val;
  logic [REM_W-1:0]          numer;
  logic                      div_start;
  logic                      div_done;
  logic [CODE_W-1:0]         div_quot;
  logic                      out_free;
  logic                      out_load;

  ttsdg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ttsdg_ram #(
    .WIDTH (PHASE_W),
    .DEPTH (NUM_TONES)
  ) u_phase_ram (
    .clk     (clk),
    .we      (ph_we),
    .waddr   (tone_r),
    .wdata   (ph_new),
    .raddr   (ph_raddr),
    .rdata_r (ph_rdata)
  );

  ttsdg_sine_rom #(
    .ADDR_BITS (SINE_ADDR_BITS)
  ) u_sine_rom (
    .clk    (clk),
    .addr   (ph_new[PHASE_W-1 -: SINE_ADDR_BITS]),
    .sine_r (sine)
  );

  ttsdg_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .numer   (numer),
    .sum_amp (sum_amp),
    .done    (div_done),
    .quot    (div_quot)
  );

  assign step_sel = (NUM_TONES == 1 || tone_r == '0) ? cfg.step_a : cfg.step_b;
  assign amp_sel  = (NUM_TONES == 1 || tone_r == '0) ? cfg.amp_a : cfg.amp_b;
  assign sum_amp  = (NUM_TONES > 1) ? (SUM_W'(cfg.amp_a) + SUM_W'(cfg.amp_b))
                                    : SUM_W'(cfg.amp_a);
  assign ph_old   = (valid_r[tone_r] && !clr_r) ? ph_rdata : '0;
  assign ph_new   = ph_old + step_sel;
  assign n_val    = NUM_W'(acc_r) + NUM_W'({sum_amp, {HALF_SHIFT{1'b0}}});
  assign numer    = (REM_W'(n_val) << CODE_W) - REM_W'(n_val);
  assign out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_dac_code = code_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC: begin
        if (tone_r == LAST_TONE) begin
          state_nxt = ST_PREP;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_PREP: begin
        if (sum_amp == '0) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    ph_we     = (state_r == ST_READ);
    ph_raddr  = (state_r == ST_ACC) ? (tone_r + TW'(1)) : '0;
    div_start = (state_r == ST_PREP) && (sum_amp != '0);
    out_load  = (state_r == ST_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ph_we) begin
        valid_r[tone_r] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        clr_r  <= in_clear_phases;
        tone_r <= '0;
        acc_r  <= '0;
      end
      ST_MUL: begin
        prod_r <= $signed({1'b0, amp_sel}) * sine;
      end
      ST_ACC: begin
        acc_r <= acc_r + ACC_W'(prod_r);
        if (tone_r != LAST_TONE) begin
          tone_r <= tone_r + TW'(1);
        end
      end
      ST_OUT: begin
        if (out_free) begin
          code_r <= (sum_amp == '0) ? CODE_MID : div_quot;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_READ))
    else $error("Accepted request did not start a phase read.");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("Divider finished outside the divide state.");

  a_out_from_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_OUT))
    else $error("Result became valid without passing the output state.");

  a_phase_addr: assert property (@(posedge clk) disable iff (!rst_n)
    ph_we |-> (tone_r <= LAST_TONE))
    else $error("Phase write beyond the last tone.");
`endif

endmodule

FILE: bench/tb_two_tone_sine_dac_generator_top.sv
`timescale 1ns / 1ps

module tb_two_tone_sine_dac_generator_top;
  import ttsdg_pkg::*;

  localparam int LUT_BITS = SINE_ADDR_BITS_DEF;
  localparam int LUT_SIZE = 1 << LUT_BITS;
  localparam int QUARTER = 1 << (LUT_BITS - 2);
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] UNIT_Q30 = 64'd1 << 30;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;

  class dac_code_tracker;
    logic [AMP_W-1:0] amp [2];
    logic [STEP_W-1:0] step [2];
    logic [PHASE_W-1:0] phase [2];
    int sine_lut [LUT_SIZE];
    int unsigned horner_div [5] = '{110, 72, 42, 20, 6};
    logic [CODE_W-1:0] pending_codes [$];
    int errors;
    int samples;
    int clears;

    function new();
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] h;
      logic [63:0] s;
      logic [63:0] mag;
      int unsigned q;
      int unsigned t;
      int unsigned u;
      for (int k = 0; k < LUT_SIZE; k++) begin
        q = (k >> (LUT_BITS - 2)) & 3;
        t = k & (QUARTER - 1);
        u = (q & 1) ? QUARTER - t : t;
        x = (PI_HALF_Q30 * 64'(u)) >> (LUT_BITS - 2);
        x2 = (x * x) >> 30;
        h = UNIT_Q30;
        for (int i = 0; i < 5; i++) begin
          h = UNIT_Q30 - ((x2 * h) >> 30) / 64'(horner_div[i]);
        end
        s = (x * h) >> 30;
        mag = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (mag > 64'd32767) begin
          mag = 64'd32767;
        end
        sine_lut[k] = (q & 2) ? -int'(mag) : int'(mag);
      end
      amp[0] = AMP_A_RST;
      amp[1] = AMP_B_RST;
      step[0] = STEP_A_RST;
      step[1] = STEP_B_RST;
      phase[0] = '0;
      phase[1] = '0;
      errors = 0;
      samples = 0;
      clears = 0;
    endfunction

    function void write_reg(reg_idx_t r, logic [DATA_W-1:0] v);
      case (r)
        REG_AMP_A: amp[0] = v[AMP_W-1:0];
        REG_AMP_B: amp[1] = v[AMP_W-1:0];
        REG_STEP_A: step[0] = v;
        REG_STEP_B: step[1] = v;
        default: ;
      endcase
    endfunction

    function logic [DATA_W-1:0] reg_value(reg_idx_t r);
      case (r)
        REG_AMP_A: return DATA_W'(amp[0]);
        REG_AMP_B: return DATA_W'(amp[1]);
        REG_STEP_A: return step[0];
        default: return step[1];
      endcase
    endfunction

    function void add_sample(logic clr);
      longint acc;
      longint total;
      longint num;
      logic [CODE_W-1:0] code;
      if (clr) begin
        phase[0] = '0;
        phase[1] = '0;
      end
      acc = 0;
      total = 0;
      for (int i = 0; i < 2; i++) begin
        phase[i] = phase[i] + step[i];
        acc += longint'(amp[i]) * sine_lut[phase[i][PHASE_W-1 -: LUT_BITS]];
        total += longint'(amp[i]);
      end
      if (total == 0) begin
        code = CODE_MID;
      end else begin
        num = ((acc + total * 32768) * 255) / (total * 65536);
        code = (num > 255) ? 8'd255 : num[CODE_W-1:0];
      end
      pending_codes.push_back(code);
      samples++;
      if (clr) begin
        clears++;
      end
    endfunction

    function void check_code(logic [CODE_W-1:0] got);
      logic [CODE_W-1:0] want;
      if (pending_codes.size() == 0) begin
        errors++;
        $display("%0t: unexpected dac_code, expected none, actual %0d", $time, got);
      end else begin
        want = pending_codes.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: dac_code mismatch, expected %0d, actual %0d", $time, want, got);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_clear_phases = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CODE_W-1:0] out_dac_code;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  int send_idle_pct = 9;
  int recv_idle_pct = 77;
  int settings_used = 0;
  int stall_cycles = 0;
  dac_code_tracker codes = new();

  two_tone_sine_dac_generator_top u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_clear_phases(in_clear_phases),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_dac_code(out_dac_code),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      codes.check_code(out_dac_code);
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, stall_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic apb_write(reg_idx_t r, logic [DATA_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    codes.write_reg(r, v);
  endtask

  task automatic apb_read_check(reg_idx_t r);
    logic [DATA_W-1:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {r, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    want = codes.reg_value(r);
    if (prdata !== want) begin
      codes.errors++;
      $display("%0t: register %0d readback mismatch, expected %0h, actual %0h",
               $time, r, want, prdata);
    end
  endtask

  task automatic check_all_regs();
    for (int i = 0; i < 4; i++) begin
      apb_read_check(reg_idx_t'(i));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_sample(logic clr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_clear_phases <= clr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    codes.add_sample(clr);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (codes.pending_codes.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(logic [AMP_W-1:0] a, logic [AMP_W-1:0] b, logic [STEP_W-1:0] sa,
                           logic [STEP_W-1:0] sb, int n, int clear_pct, bit clear_first);
    logic clr;
    wait_drained();
    apb_write(REG_AMP_A, DATA_W'(a));
    apb_write(REG_AMP_B, DATA_W'(b));
    apb_write(REG_STEP_A, sa);
    apb_write(REG_STEP_B, sb);
    check_all_regs();
    settings_used++;
    for (int i = 0; i < n; i++) begin
      clr = (i == 0 && clear_first) || ($urandom_range(99) < clear_pct);
      send_sample(clr);
    end
  endtask

  function automatic logic [AMP_W-1:0] rand_amplitude();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 16'd16384;
      default: return AMP_W'($urandom);
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] rand_step();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      2: return STEP_W'($urandom_range(32'h0400_0000));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_all_regs();
    settings_used++;
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b0);

    run_phase('0, '0, $urandom, $urandom, 2, 50, 1'b1);
    run_phase('1, '1, '0, '0, 2, 0, 1'b1);
    run_phase('1, 16'd1, '1, '1, 3, 0, 1'b1);
    run_phase('1, '0, 32'h4000_0000, 32'h8000_0000, 5, 0, 1'b1);
    run_phase('0, 16'd16384, 32'h0040_0000, 32'hC000_0000, 4, 0, 1'b1);
    run_phase(16'd1, '0, 32'd1, '0, 3, 0, 1'b1);

    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 77;
        end
        1: begin
          send_idle_pct = 77;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int c = 0; c < 4; c++) begin
        run_phase(rand_amplitude(), rand_amplitude(), rand_step(), rand_step(), 54, 8,
                  $urandom_range(1));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d DAC samples, %0d of them with a phase clear, over %0d settings.",
             codes.samples, codes.clears, settings_used);
    $display("Settings included zero and full amplitudes, zero and maximum phase steps.");
    if (codes.errors == 0 && codes.pending_codes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/ttsdg_pkg.sv
rtl/core/ttsdg_ram.sv
rtl/core/ttsdg_sine_rom.sv
rtl/core/ttsdg_regs.sv
rtl/core/ttsdg_div.sv
rtl/core/two_tone_sine_dac_generator_top.sv
bench/tb_two_tone_sine_dac_generator_top.sv
